>>> sv/rice_partition_param_search_core_assert.svh
// Assertion macros for the Rice partition parameter search core.
// No dependencies; included by the modules that carry assertions.
`ifndef RICE_PARTITION_PARAM_SEARCH_CORE_ASSERT_SVH
`define RICE_PARTITION_PARAM_SEARCH_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define RPPS_ASSERT_IMPLIES(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
`define RPPS_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`else
`define RPPS_ASSERT_IMPLIES(label, clk, rst, lhs, rhs, msg)
`define RPPS_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg)
`endif
`endif

>>> sv/rpps_pkg.sv
// Shared constants and controller/datapath command and status types.
// No dependencies.
package rpps_pkg;
   localparam int BLOCK_MAX_DEF  = 4096;
   localparam int MAX_ORDER_DEF  = 6;
   localparam int NUM_PARAMS_DEF = 8;

   localparam int SAMPLE_W    = 32;
   localparam int COUNT_W     = 13;
   localparam int SUM_W       = 45;
   localparam int TOTAL_W     = 48;
   localparam int ORDER_W     = 3;
   localparam int PART_W      = 6;
   localparam int PARAM_W     = 3;
   localparam int HEADER_BITS = 4;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_BLOCK_SIZE_ADDR = '0;

   typedef struct packed {
      logic                 sample_en;
      logic                 clear;
      logic                 rd_en;
      logic [ORDER_W-1:0]   order;
      logic [PART_W-1:0]    part;
      logic                 diff_load;
      logic                 scan_step;
      logic [PARAM_W-1:0]   scan_r;
      logic                 total_init;
      logic                 total_acc;
      logic                 order_commit;
      logic                 emit_load;
   } cmd_type;

   typedef struct packed {
      logic                 last_sample;
      logic [ORDER_W-1:0]   order_last;
      logic [ORDER_W-1:0]   best_order;
   } stat_type;
endpackage

>>> sv/rpps_dpath.sv
// Datapath: cost accumulation lanes, per-order boundary memories, min/total search.
// Depends on rpps_pkg.
module rpps_dpath #(
   parameter int BLOCK_MAX  = rpps_pkg::BLOCK_MAX_DEF,
   parameter int MAX_ORDER  = rpps_pkg::MAX_ORDER_DEF,
   parameter int NUM_PARAMS = rpps_pkg::NUM_PARAMS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rpps_pkg::cmd_type                   cmd,
   output rpps_pkg::stat_type                  stat,
   input  logic [rpps_pkg::COUNT_W-1:0]        block_size,
   input  logic signed [rpps_pkg::SAMPLE_W-1:0] sample,
   output logic [rpps_pkg::ORDER_W-1:0]        rsp_order,
   output logic [rpps_pkg::PART_W-1:0]         rsp_part_index,
   output logic [rpps_pkg::PARAM_W-1:0]        rsp_rice_k,
   output logic [rpps_pkg::TOTAL_W-1:0]        rsp_best_total_bits,
   output logic                                rsp_last
);
   import rpps_pkg::*;

   localparam int NORD  = MAX_ORDER + 1;
   localparam int KW    = MAX_ORDER + 1;
   localparam int RW    = $clog2(NUM_PARAMS);
   localparam int ROW_W = NUM_PARAMS * SUM_W;

   logic [COUNT_W-1:0]  b_eff;
   logic [SAMPLE_W-1:0] u;
   logic [COUNT_W-1:0]  count_ff;
   logic                last_sample;
   logic                block_clr;
   logic [SUM_W-1:0]    sums_ff [NUM_PARAMS];
   logic [ROW_W-1:0]    row_new;
   logic [COUNT_W-1:0]  len_a [NORD];
   logic [ROW_W-1:0]    rd_ff [NORD];
   logic [ROW_W-1:0]    row_sel;
   logic [ROW_W-1:0]    prev_ff;
   logic [SUM_W-1:0]    diff_in [NUM_PARAMS];
   logic [SUM_W-1:0]    diff_ff [NUM_PARAMS];
   logic [SUM_W-1:0]    best_cost_ff;
   logic [PARAM_W-1:0]  best_r_ff;
   logic [TOTAL_W-1:0]  total_ff;
   logic [TOTAL_W-1:0]  best_total_ff;
   logic [ORDER_W-1:0]  best_order_ff;
   logic [ORDER_W-1:0]  order_last;
   logic [ORDER_W-1:0]  rsp_order_ff;
   logic [PART_W-1:0]   rsp_part_ff;
   logic [PARAM_W-1:0]  rsp_param_ff;
   logic [TOTAL_W-1:0]  rsp_total_ff;
   logic                rsp_last_ff;

   // zero maps to one, oversize clamps to the block limit
   always_comb begin
      if (block_size == '0) begin
         b_eff = COUNT_W'(1);
      end else if (block_size > COUNT_W'(BLOCK_MAX)) begin
         b_eff = COUNT_W'(BLOCK_MAX);
      end else begin
         b_eff = block_size;
      end
   end

   assign u           = {sample[SAMPLE_W-2:0], 1'b0} ^ {SAMPLE_W{sample[SAMPLE_W-1]}};
   assign last_sample = (count_ff + COUNT_W'(1)) == b_eff;
   assign block_clr   = cmd.clear || (cmd.sample_en && last_sample);

   always_ff @(posedge clock) begin
      if (reset || block_clr) begin
         count_ff <= '0;
      end else if (cmd.sample_en) begin
         count_ff <= count_ff + COUNT_W'(1);
      end
   end

   // one accumulation lane per Rice parameter
   for (genvar r = 0; r < NUM_PARAMS; r++) begin : g_lane
      logic [SUM_W-1:0] sum_in;
      assign sum_in = sums_ff[r] + SUM_W'(r + 1) + SUM_W'(u >> r);
      assign row_new[r*SUM_W +: SUM_W] = sum_in;
      always_ff @(posedge clock) begin
         if (reset || block_clr) begin
            sums_ff[r] <= '0;
         end else if (cmd.sample_en) begin
            sums_ff[r] <= sum_in;
         end
      end
   end

   // per order: partition position counter and boundary memory
   for (genvar p = 0; p < NORD; p++) begin : g_ord
      logic [COUNT_W-1:0] pos_ff;
      logic [KW-1:0]      k_ff;
      logic [ROW_W-1:0]   mem [2**p];
      logic               hit;
      logic               capture;

      assign len_a[p] = b_eff >> p;
      assign hit      = (len_a[p] != '0) && ((pos_ff + COUNT_W'(1)) == len_a[p]);
      assign capture  = cmd.sample_en && hit && (k_ff < KW'(2**p));

      always_ff @(posedge clock) begin
         if (reset || block_clr) begin
            pos_ff <= '0;
            k_ff   <= '0;
         end else if (cmd.sample_en && len_a[p] != '0) begin
            if (hit) begin
               pos_ff <= '0;
               if (k_ff < KW'(2**p)) begin
                  k_ff <= k_ff + KW'(1);
               end
            end else begin
               pos_ff <= pos_ff + COUNT_W'(1);
            end
         end
      end

      if (p == 0) begin : g_one
         always_ff @(posedge clock) begin
            if (capture) begin
               mem[0] <= row_new;
            end
            if (cmd.rd_en) begin
               rd_ff[p] <= mem[0];
            end
         end
      end else begin : g_many
         always_ff @(posedge clock) begin
            if (capture) begin
               mem[k_ff[p-1:0]] <= row_new;
            end
            if (cmd.rd_en) begin
               rd_ff[p] <= mem[cmd.part[p-1:0]];
            end
         end
      end
   end

   always_comb begin
      row_sel    = '0;
      order_last = '0;
      for (int p = 0; p < NORD; p++) begin
         if (cmd.order == ORDER_W'(p)) begin
            row_sel = rd_ff[p];
         end
         if (len_a[p] != '0) begin
            order_last = ORDER_W'(p);
         end
      end
   end

   for (genvar r = 0; r < NUM_PARAMS; r++) begin : g_diff
      logic [SUM_W-1:0] prv;
      assign prv        = (cmd.part == '0) ? '0 : prev_ff[r*SUM_W +: SUM_W];
      assign diff_in[r] = row_sel[r*SUM_W +: SUM_W] - prv;
      always_ff @(posedge clock) begin
         if (cmd.diff_load) begin
            diff_ff[r] <= diff_in[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.diff_load) begin
         prev_ff      <= row_sel;
         best_cost_ff <= diff_in[0];
         best_r_ff    <= '0;
      end else if (cmd.scan_step) begin
         // strict less-than keeps the lowest parameter on ties
         if (diff_ff[cmd.scan_r[RW-1:0]] < best_cost_ff) begin
            best_cost_ff <= diff_ff[cmd.scan_r[RW-1:0]];
            best_r_ff    <= cmd.scan_r;
         end
      end
      if (cmd.total_init) begin
         total_ff <= TOTAL_W'(HEADER_BITS) << cmd.order;
      end else if (cmd.total_acc) begin
         total_ff <= total_ff + TOTAL_W'(best_cost_ff);
      end
      if (cmd.order_commit) begin
         if (cmd.order == '0 || total_ff < best_total_ff) begin
            best_total_ff <= total_ff;
            best_order_ff <= cmd.order;
         end
      end
      if (cmd.emit_load) begin
         rsp_order_ff <= best_order_ff;
         rsp_part_ff  <= cmd.part;
         rsp_param_ff <= best_r_ff;
         rsp_total_ff <= best_total_ff;
         rsp_last_ff  <= {1'b0, cmd.part} ==
                         (((PART_W+1)'(1) << best_order_ff) - (PART_W+1)'(1));
      end
   end

   assign stat.last_sample = last_sample;
   assign stat.order_last  = order_last;
   assign stat.best_order  = best_order_ff;

   assign rsp_order           = rsp_order_ff;
   assign rsp_part_index      = rsp_part_ff;
   assign rsp_rice_k          = rsp_param_ff;
   assign rsp_best_total_bits = rsp_total_ff;
   assign rsp_last            = rsp_last_ff;
endmodule

>>> sv/rpps_ctrl.sv
// Controller: sequences sample intake, the order/partition search and result output.
// Depends on rpps_pkg and the assertion macro header.
`include "rice_partition_param_search_core_assert.svh"
module rpps_ctrl #(
   parameter int NUM_PARAMS = rpps_pkg::NUM_PARAMS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cfg_wr,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rpps_pkg::cmd_type  cmd,
   input  rpps_pkg::stat_type stat
);
   import rpps_pkg::*;

   typedef enum logic [3:0] {
      S_ACCUM, S_RD, S_DIFF, S_SCAN, S_ACC, S_COMMIT, S_EMIT_START, S_LOAD, S_OUT
   } state_type;

   state_type          state_ff;
   logic [ORDER_W-1:0] p_ff;
   logic [PART_W-1:0]  i_ff;
   logic [PARAM_W-1:0] r_ff;
   logic               emit_ff;
   logic               rsp_valid_ff;
   logic               last_part;

   assign last_part = {1'b0, i_ff} == (((PART_W+1)'(1) << p_ff) - (PART_W+1)'(1));
   assign req_ready = (state_ff == S_ACCUM);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd              = '0;
      cmd.clear        = cfg_wr;
      cmd.order        = p_ff;
      cmd.part         = i_ff;
      cmd.scan_r       = r_ff;
      cmd.sample_en    = (state_ff == S_ACCUM) && req_valid;
      cmd.rd_en        = (state_ff == S_RD);
      cmd.total_init   = (state_ff == S_RD) && !emit_ff && (i_ff == '0);
      cmd.diff_load    = (state_ff == S_DIFF);
      cmd.scan_step    = (state_ff == S_SCAN);
      cmd.total_acc    = (state_ff == S_ACC);
      cmd.order_commit = (state_ff == S_COMMIT);
      cmd.emit_load    = (state_ff == S_LOAD);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_ACCUM;
         p_ff         <= '0;
         i_ff         <= '0;
         r_ff         <= '0;
         emit_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_ACCUM: begin
               if (req_valid && stat.last_sample) begin
                  p_ff     <= '0;
                  i_ff     <= '0;
                  emit_ff  <= 1'b0;
                  state_ff <= S_RD;
               end
            end
            S_RD: begin
               state_ff <= S_DIFF;
            end
            S_DIFF: begin
               r_ff     <= PARAM_W'(1);
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               if (r_ff == PARAM_W'(NUM_PARAMS - 1)) begin
                  state_ff <= emit_ff ? S_LOAD : S_ACC;
               end else begin
                  r_ff <= r_ff + PARAM_W'(1);
               end
            end
            S_ACC: begin
               if (last_part) begin
                  state_ff <= S_COMMIT;
               end else begin
                  i_ff     <= i_ff + PART_W'(1);
                  state_ff <= S_RD;
               end
            end
            S_COMMIT: begin
               i_ff <= '0;
               if (p_ff == stat.order_last) begin
                  state_ff <= S_EMIT_START;
               end else begin
                  p_ff     <= p_ff + ORDER_W'(1);
                  state_ff <= S_RD;
               end
            end
            S_EMIT_START: begin
               p_ff     <= stat.best_order;
               i_ff     <= '0;
               emit_ff  <= 1'b1;
               state_ff <= S_RD;
            end
            S_LOAD: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_OUT;
            end
            S_OUT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (last_part) begin
                     emit_ff  <= 1'b0;
                     state_ff <= S_ACCUM;
                  end else begin
                     i_ff     <= i_ff + PART_W'(1);
                     state_ff <= S_RD;
                  end
               end
            end
            default: begin
               state_ff <= S_ACCUM;
            end
         endcase
      end
   end

   `RPPS_ASSERT_IMPLIES(a_no_overlap, clock, reset, rsp_valid_ff, !req_ready, "intake during output")
   `RPPS_ASSERT_NEXT(a_search_starts, clock, reset, cmd.sample_en && stat.last_sample, state_ff == S_RD && !emit_ff, "search did not start")
   `RPPS_ASSERT_IMPLIES(a_emit_order, clock, reset, emit_ff, p_ff == stat.best_order, "emit order mismatch")
endmodule

>>> sv/rice_partition_param_search_core.sv
// Samples enter one per cycle while req_ready is high, in the intake state only; after
// the last sample of a block the search walks every valid order p and its 2^p partitions,
// scanning the Rice parameters of each partition in turn, then emits one result per
// partition of the chosen order; each result waits on any output stall.
// Reset (synchronous, active high) sets block_size to BLOCK_MAX and clears counts
// and running sums; boundary memories need no clearing.
module rice_partition_param_search_core #(
   parameter int BLOCK_MAX  = rpps_pkg::BLOCK_MAX_DEF,
   parameter int MAX_ORDER  = rpps_pkg::MAX_ORDER_DEF,
   parameter int NUM_PARAMS = rpps_pkg::NUM_PARAMS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input transactions: one residual sample each
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [rpps_pkg::SAMPLE_W-1:0]  req_sample,
   // result transactions: one per partition of the chosen order
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [rpps_pkg::ORDER_W-1:0]          rsp_order,
   output logic [rpps_pkg::PART_W-1:0]           rsp_part_index,
   output logic [rpps_pkg::PARAM_W-1:0]          rsp_rice_k,
   output logic [rpps_pkg::TOTAL_W-1:0]          rsp_best_total_bits,
   output logic                                  rsp_last,
   // register port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [rpps_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [rpps_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [rpps_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);
   import rpps_pkg::*;

   logic [COUNT_W-1:0] block_size_ff;
   logic               cfg_wr;
   cmd_type            cmd;
   stat_type           stat;

   // register write completes in the access phase; pready is tied high
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr == CSR_BLOCK_SIZE_ADDR);

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff <= COUNT_W'(BLOCK_MAX);
      end else if (cfg_wr) begin
         block_size_ff <= csr_pwdata[COUNT_W-1:0];
      end
   end

   // raw value reads back; clamping happens in the datapath
   assign csr_prdata = (csr_paddr == CSR_BLOCK_SIZE_ADDR) ?
                       CSR_DATA_W'(block_size_ff) : '0;

   // controller: owns the handshakes and walks orders and partitions
   rpps_ctrl #(
      .NUM_PARAMS (NUM_PARAMS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg_wr    (cfg_wr),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // datapath: cost lanes, boundary memories, search arithmetic, output registers
   rpps_dpath #(
      .BLOCK_MAX  (BLOCK_MAX),
      .MAX_ORDER  (MAX_ORDER),
      .NUM_PARAMS (NUM_PARAMS)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .block_size          (block_size_ff),
      .sample              (req_sample),
      .rsp_order           (rsp_order),
      .rsp_part_index      (rsp_part_index),
      .rsp_rice_k          (rsp_rice_k),
      .rsp_best_total_bits (rsp_best_total_bits),
      .rsp_last            (rsp_last)
   );
endmodule
